@@ hw/rtl/xcfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package xcfr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd5;

   localparam logic [BYTE_W-1:0] RST_DEVICE_ADDRESS   = 8'h00;
   localparam logic [BYTE_W-1:0] RST_DEVICE_TYPE_CODE = 8'h60;
   localparam logic [BYTE_W-1:0] RST_START_BYTE       = 8'h68;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_DEVICE_ADDRESS   = 2'd0,
      CSR_DEVICE_TYPE_CODE = 2'd1,
      CSR_START_BYTE       = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_LEN   = 3'd1,
      PH_TYPE  = 3'd2,
      PH_ADDR  = 3'd3,
      PH_CMD   = 3'd4,
      PH_DATA  = 3'd5,
      PH_CHK   = 3'd6,
      PH_DRAIN = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CMD     = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_VERDICT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      VERDICT_OK        = 3'd0,
      VERDICT_NO_HEADER = 3'd1,
      VERDICT_TYPE      = 3'd2,
      VERDICT_ADDRESS   = 3'd3,
      VERDICT_CHECKSUM  = 3'd4,
      VERDICT_TRUNCATED = 3'd5,
      VERDICT_LENGTH    = 3'd6
   } verdict_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              buffer_end;
   } req_type;

   typedef struct packed {
      kind_type          out_kind;
      logic [BYTE_W-1:0] out_byte;
      verdict_type       verdict_code;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] device_address;
      logic [BYTE_W-1:0] device_type_code;
      logic [BYTE_W-1:0] start_byte;
   } cfg_type;

endpackage

`default_nettype wire

@@ hw/rtl/xcfr_frame_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xcfr_frame_fsm import xcfr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output logic         result_valid,
   output rsp_type      result,
   output phase_type    phase
);

   phase_type         phase_ff,  phase_in;
   logic [BYTE_W-1:0] offset_ff, offset_in;
   logic [BYTE_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0] xor_ff,    xor_in;
   logic [BYTE_W:0]   next_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         offset_ff <= '0;
         length_ff <= '0;
         xor_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         xor_ff    <= xor_in;
      end
   end

   // next offset in data phase plus one, nine bits so the wrap is seen
   assign next_pos = {1'b0, offset_ff} + 9'd2;

   always_comb begin
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      length_in    = length_ff;
      xor_in       = xor_ff;
      result_valid = 1'b0;
      result       = '{out_kind: KIND_CMD, out_byte: '0, verdict_code: VERDICT_OK};

      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (item.rx_byte == cfg.start_byte) begin
                  xor_in    = item.rx_byte;
                  offset_in = '0;
                  phase_in  = PH_LEN;
               end else if (item.buffer_end) begin
                  result_valid        = 1'b1;
                  result.out_kind     = KIND_VERDICT;
                  result.verdict_code = VERDICT_NO_HEADER;
                  phase_in            = PH_DRAIN;
               end
            end
            PH_LEN: begin
               length_in = item.rx_byte;
               xor_in    = xor_ff ^ item.rx_byte;
               offset_in = 8'd1;
               phase_in  = PH_TYPE;
            end
            PH_TYPE: begin
               xor_in    = xor_ff ^ item.rx_byte;
               offset_in = 8'd2;
               if (item.rx_byte != cfg.device_type_code) begin
                  result_valid        = 1'b1;
                  result.out_kind     = KIND_VERDICT;
                  result.verdict_code = VERDICT_TYPE;
                  phase_in            = PH_DRAIN;
               end else begin
                  phase_in = PH_ADDR;
               end
            end
            PH_ADDR: begin
               xor_in    = xor_ff ^ item.rx_byte;
               offset_in = 8'd3;
               priority if (item.rx_byte != cfg.device_address) begin
                  result_valid        = 1'b1;
                  result.out_kind     = KIND_VERDICT;
                  result.verdict_code = VERDICT_ADDRESS;
                  phase_in            = PH_DRAIN;
               end else if (length_ff < MIN_FRAME_LEN) begin
                  result_valid        = 1'b1;
                  result.out_kind     = KIND_VERDICT;
                  result.verdict_code = VERDICT_LENGTH;
                  phase_in            = PH_DRAIN;
               end else begin
                  phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               xor_in          = xor_ff ^ item.rx_byte;
               offset_in       = 8'd4;
               result_valid    = 1'b1;
               result.out_kind = KIND_CMD;
               result.out_byte = item.rx_byte;
               phase_in        = (length_ff == MIN_FRAME_LEN) ? PH_CHK : PH_DATA;
            end
            PH_DATA: begin
               xor_in          = xor_ff ^ item.rx_byte;
               offset_in       = offset_ff + 8'd1;
               result_valid    = 1'b1;
               result.out_kind = KIND_DATA;
               result.out_byte = item.rx_byte;
               if (next_pos >= {1'b0, length_ff}) begin
                  phase_in = PH_CHK;
               end
            end
            PH_CHK: begin
               offset_in           = length_ff;
               result_valid        = 1'b1;
               result.out_kind     = KIND_VERDICT;
               result.verdict_code = (xor_ff == item.rx_byte) ? VERDICT_OK
                                                               : VERDICT_CHECKSUM;
               phase_in            = PH_DRAIN;
            end
            PH_DRAIN: begin
            end
            default: begin
            end
         endcase

         if (item.buffer_end) begin
            // buffer ran out inside a frame: truncated replaces any result
            if (phase_in != PH_DRAIN && phase_in != PH_HUNT) begin
               result_valid        = 1'b1;
               result.out_kind     = KIND_VERDICT;
               result.out_byte     = '0;
               result.verdict_code = VERDICT_TRUNCATED;
            end
            phase_in  = PH_HUNT;
            offset_in = '0;
            length_in = '0;
            xor_in    = '0;
         end
      end
   end

   assign phase = phase_ff;

endmodule

`default_nettype wire

@@ hw/rtl/xor_checked_frame_receiver_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// XOR-checked frame receiver. Feed the bytes of one received buffer, one
// transaction per byte, with buffer_end set on the last. The block hunts for
// the start byte, then reads length, device type, device address, command and
// data, and checks the XOR of the first length bytes against the byte after
// them. Command and data bytes come out as they arrive and are tentative until
// the verdict, which is the single last result of a frame; bytes after the
// verdict are dropped up to the buffer end. The frame state advances in the
// cycle a byte is accepted, and a new byte can be taken every cycle while
// req_stall is low. Results sit in an output register backed by one skid
// entry, so req_stall rises only when both are full. Configuration (address,
// type code, start byte) must be written while no buffer is in flight.

module xor_checked_frame_receiver_core import xcfr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   // input byte channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   // configuration write port
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [BYTE_W-1:0] csr_write_data
);

   cfg_type   cfg_ff;
   logic      req_accept;
   logic      rsp_pop;
   logic      fsm_valid;
   rsp_type   fsm_result;
   phase_type fsm_phase;

   // output register plus skid entry
   logic    main_valid_ff, main_valid_in;
   rsp_type main_data_ff,  main_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff,  skid_data_in;
   logic    main_free;

   // configuration registers; an unknown index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address   <= RST_DEVICE_ADDRESS;
         cfg_ff.device_type_code <= RST_DEVICE_TYPE_CODE;
         cfg_ff.start_byte       <= RST_START_BYTE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS:   cfg_ff.device_address   <= csr_write_data;
            CSR_DEVICE_TYPE_CODE: cfg_ff.device_type_code <= csr_write_data;
            CSR_START_BYTE:       cfg_ff.start_byte       <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = main_valid_ff && !rsp_stall;

   xcfr_frame_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .item         (req_data),
      .cfg          (cfg_ff),
      .result_valid (fsm_valid),
      .result       (fsm_result),
      .phase        (fsm_phase)
   );

   // The skid entry moves up when the output register drains; a new result
   // goes to the output register if that ends up empty, else to the skid.
   always_comb begin
      main_valid_in = rsp_pop ? skid_valid_ff : main_valid_ff;
      main_data_in  = (rsp_pop && skid_valid_ff) ? skid_data_ff : main_data_ff;
      skid_valid_in = rsp_pop ? 1'b0 : skid_valid_ff;
      skid_data_in  = skid_data_ff;
      main_free     = !main_valid_in;
      if (fsm_valid) begin
         if (main_free) begin
            main_valid_in = 1'b1;
            main_data_in  = fsm_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = fsm_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

   // skid entry is only ever used behind a full output register
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a result with the output register empty");

   // every buffer end returns the frame logic to hunting
   a_end_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.buffer_end) |=> (fsm_phase == PH_HUNT))
      else $error("frame logic not hunting after buffer end");

   // command and data results never carry a verdict code
   a_byte_no_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind != KIND_VERDICT)
         |-> (rsp_data.verdict_code == VERDICT_OK))
      else $error("byte result with non-zero verdict code");

   // a verdict carries no byte
   a_verdict_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind == KIND_VERDICT) |-> (rsp_data.out_byte == '0))
      else $error("verdict with non-zero byte");

endmodule

`default_nettype wire

@@ sim/xor_checked_frame_receiver_core_tb.sv @@
`timescale 1ns / 1ps

module xor_checked_frame_receiver_core_tb;
   import xcfr_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 3;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 160;
   localparam int RANDOM_PHASES = 8;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   req_type           req_data         = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   rsp_type           rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [1:0]        csr_index        = '0;
   logic [BYTE_W-1:0] csr_write_data   = '0;

   // frame tracking copy, updated from observed transactions
   cfg_type           shadow_cfg;
   phase_type         frame_phase;
   logic [BYTE_W-1:0] frame_offset;
   logic [BYTE_W-1:0] frame_len;
   logic [BYTE_W-1:0] frame_xor;

   rsp_type           expected_results[$];
   logic [BYTE_W-1:0] buffer_bytes[$];
   int                fail_count = 0;
   int                bytes_sent = 0;
   int                idle_pct   = 0;
   int                stall_pct  = 0;

   xor_checked_frame_receiver_core dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_write_enable,
      .csr_index,
      .csr_write_data
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   function automatic void clear_frame();
      frame_phase  = PH_HUNT;
      frame_offset = '0;
      frame_len    = '0;
      frame_xor    = '0;
   endfunction

   function automatic void predict_frame_byte(input logic [BYTE_W-1:0] b, input logic last,
                                              output logic hit, output rsp_type r);
      hit = 1'b0;
      r   = '{out_kind: KIND_CMD, out_byte: 8'h00, verdict_code: VERDICT_OK};
      case (frame_phase)
         PH_HUNT: begin
            if (b == shadow_cfg.start_byte) begin
               frame_xor    = b;
               frame_offset = '0;
               frame_phase  = PH_LEN;
            end else if (last) begin
               hit            = 1'b1;
               r.out_kind     = KIND_VERDICT;
               r.verdict_code = VERDICT_NO_HEADER;
               frame_phase    = PH_DRAIN;
            end
         end
         PH_LEN: begin
            frame_len    = b;
            frame_xor    = frame_xor ^ b;
            frame_offset = 8'd1;
            frame_phase  = PH_TYPE;
         end
         PH_TYPE: begin
            frame_xor    = frame_xor ^ b;
            frame_offset = 8'd2;
            if (b != shadow_cfg.device_type_code) begin
               hit            = 1'b1;
               r.out_kind     = KIND_VERDICT;
               r.verdict_code = VERDICT_TYPE;
               frame_phase    = PH_DRAIN;
            end else begin
               frame_phase = PH_ADDR;
            end
         end
         PH_ADDR: begin
            frame_xor    = frame_xor ^ b;
            frame_offset = 8'd3;
            if (b != shadow_cfg.device_address) begin
               hit            = 1'b1;
               r.out_kind     = KIND_VERDICT;
               r.verdict_code = VERDICT_ADDRESS;
               frame_phase    = PH_DRAIN;
            end else if (frame_len < MIN_FRAME_LEN) begin
               hit            = 1'b1;
               r.out_kind     = KIND_VERDICT;
               r.verdict_code = VERDICT_LENGTH;
               frame_phase    = PH_DRAIN;
            end else begin
               frame_phase = PH_CMD;
            end
         end
         PH_CMD: begin
            frame_xor    = frame_xor ^ b;
            frame_offset = 8'd4;
            hit          = 1'b1;
            r.out_byte   = b;
            frame_phase  = (frame_len == MIN_FRAME_LEN) ? PH_CHK : PH_DATA;
         end
         PH_DATA: begin
            frame_xor    = frame_xor ^ b;
            frame_offset = frame_offset + 8'd1;
            hit          = 1'b1;
            r.out_kind   = KIND_DATA;
            r.out_byte   = b;
            if ({1'b0, frame_offset} + 9'd1 >= {1'b0, frame_len})
               frame_phase = PH_CHK;
         end
         PH_CHK: begin
            frame_offset   = frame_len;
            hit            = 1'b1;
            r.out_kind     = KIND_VERDICT;
            r.verdict_code = (frame_xor == b) ? VERDICT_OK : VERDICT_CHECKSUM;
            frame_phase    = PH_DRAIN;
         end
         default: ;
      endcase
      // buffer end inside a frame overrides whatever this byte produced
      if (last) begin
         if (frame_phase != PH_DRAIN && frame_phase != PH_HUNT) begin
            hit = 1'b1;
            r   = '{out_kind: KIND_VERDICT, out_byte: 8'h00, verdict_code: VERDICT_TRUNCATED};
         end
         clear_frame();
      end
   endfunction

   // tracks csr writes and input transactions, checks every result transaction
   always @(posedge clock) begin : monitor
      logic    hit;
      rsp_type want;
      if (reset) begin
         shadow_cfg = '{device_address:   RST_DEVICE_ADDRESS,
                        device_type_code: RST_DEVICE_TYPE_CODE,
                        start_byte:       RST_START_BYTE};
         clear_frame();
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DEVICE_ADDRESS:   shadow_cfg.device_address   = csr_write_data;
               CSR_DEVICE_TYPE_CODE: shadow_cfg.device_type_code = csr_write_data;
               CSR_START_BYTE:       shadow_cfg.start_byte       = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_frame_byte(req_data.rx_byte, req_data.buffer_end, hit, want);
            if (hit)
               expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d byte %02h verdict %0d",
                      rsp_data.out_kind, rsp_data.out_byte, rsp_data.verdict_code);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.out_kind !== want.out_kind) begin
                  $error("out_kind: expected %0d, got %0d", want.out_kind, rsp_data.out_kind);
                  fail_count++;
               end
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.verdict_code !== want.verdict_code) begin
                  $error("verdict_code: expected %0d, got %0d",
                         want.verdict_code, rsp_data.verdict_code);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic set_pressure(input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
   endtask

   // valid stays high across back-to-back transactions
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      req_type item;
      item.rx_byte    = b;
      item.buffer_end = last;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_buffer();
      for (int i = 0; i < buffer_bytes.size(); i++)
         send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
      buffer_bytes.delete();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_reg(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] typ,
                            input logic [BYTE_W-1:0] start);
      wait_idle();
      write_reg(CSR_DEVICE_ADDRESS, addr);
      write_reg(CSR_DEVICE_TYPE_CODE, typ);
      write_reg(CSR_START_BYTE, start);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // start, length, type, address, command, data up to length-1, then checksum
   task automatic add_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] typ,
                            input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] cmd,
                            input logic bad_sum);
      int                first;
      logic [BYTE_W-1:0] sum;
      first = buffer_bytes.size();
      buffer_bytes.push_back(shadow_cfg.start_byte);
      buffer_bytes.push_back(len);
      buffer_bytes.push_back(typ);
      buffer_bytes.push_back(addr);
      buffer_bytes.push_back(cmd);
      for (int i = 5; i < len; i++)
         buffer_bytes.push_back(8'($urandom));
      sum = '0;
      for (int i = first; i < buffer_bytes.size(); i++)
         sum = sum ^ buffer_bytes[i];
      if (bad_sum)
         sum = sum ^ 8'($urandom_range(1, 255));
      buffer_bytes.push_back(sum);
   endtask

   task automatic add_junk(input int count);
      logic [BYTE_W-1:0] b;
      for (int i = 0; i < count; i++) begin
         b = 8'($urandom);
         if (b == shadow_cfg.start_byte)
            b = b ^ 8'h01;
         buffer_bytes.push_back(b);
      end
   endtask

   task automatic cut_buffer(input int keep);
      while (buffer_bytes.size() > keep)
         void'(buffer_bytes.pop_back());
   endtask

   task automatic test_good_frames();
      set_pressure(0, 0);
      add_frame(MIN_FRAME_LEN, shadow_cfg.device_type_code, shadow_cfg.device_address,
                8'h00, 1'b0);
      send_buffer();
      add_junk(2);
      add_frame(8'd6, shadow_cfg.device_type_code, shadow_cfg.device_address, 8'hFF, 1'b0);
      send_buffer();
   endtask

   task automatic test_rejections();
      logic [BYTE_W-1:0] typ;
      logic [BYTE_W-1:0] addr;
      typ  = shadow_cfg.device_type_code;
      addr = shadow_cfg.device_address;
      // wrong address, rest of the buffer drained
      add_frame(8'd7, typ, ~addr, 8'h12, 1'b0);
      send_buffer();
      // length zero, rejected once the address matches
      add_frame(8'd0, typ, addr, 8'h34, 1'b0);
      cut_buffer(4);
      send_buffer();
      add_frame(MIN_FRAME_LEN, typ, addr, 8'h56, 1'b1);
      send_buffer();
      add_junk(2);
      send_buffer();
      // start byte as the last byte of the buffer
      buffer_bytes.push_back(shadow_cfg.start_byte);
      send_buffer();
      // buffer ends on the command byte
      add_frame(8'd7, typ, addr, 8'h78, 1'b0);
      cut_buffer(5);
      send_buffer();
      // wrong type decided by the last byte itself
      add_frame(8'd6, ~typ, addr, 8'h9A, 1'b0);
      cut_buffer(3);
      send_buffer();
      wait_idle();
   endtask

   task automatic test_longest_frame();
      set_pressure(16, 16);
      add_frame(8'd255, shadow_cfg.device_type_code, shadow_cfg.device_address,
                8'($urandom), 1'b0);
      send_buffer();
      wait_idle();
   endtask

   task automatic random_buffer();
      int                shape;
      int                pre;
      int                len;
      logic [BYTE_W-1:0] typ;
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] cmd;
      shape = $urandom_range(99);
      pre   = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
      len   = ($urandom_range(99) < 80) ? $urandom_range(5, 12) : $urandom_range(13, 40);
      typ   = shadow_cfg.device_type_code;
      addr  = shadow_cfg.device_address;
      cmd   = 8'($urandom);
      add_junk(pre);
      if (shape < 55)
         add_frame(8'(len), typ, addr, cmd, 1'b0);
      else if (shape < 65)
         add_frame(8'(len), typ, addr, cmd, 1'b1);
      else if (shape < 72)
         add_frame(8'(len), typ ^ 8'($urandom_range(1, 255)), addr, cmd, 1'b0);
      else if (shape < 79)
         add_frame(8'(len), typ, addr ^ 8'($urandom_range(1, 255)), cmd, 1'b0);
      else if (shape < 85)
         add_frame(8'($urandom_range(0, 4)), typ, addr, cmd, 1'b0);
      else if (shape < 92) begin
         add_frame(8'(len), typ, addr, cmd, 1'b0);
         cut_buffer($urandom_range(pre + 1, buffer_bytes.size() - 1));
      end else if (shape < 97)
         add_junk($urandom_range(1, 6));
      else
         repeat ($urandom_range(1, 8)) buffer_bytes.push_back(8'($urandom));
      // trailing bytes after a completed frame are drained
      if (shape < 85 && $urandom_range(99) < 30)
         repeat ($urandom_range(1, 3)) buffer_bytes.push_back(8'($urandom));
      send_buffer();
   endtask

   task automatic test_random_traffic();
      int target;
      int buffers;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1:       configure(8'hFF, 8'hFF, 8'hFF);
            2:       configure(8'h00, 8'h00, 8'h00);
            5:       configure(8'hFF, 8'h00, 8'h80);
            default: configure(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         case (p % 4)
            0:       set_pressure(0, 0);
            1:       set_pressure(50, 0);
            2:       set_pressure(0, 50);
            default: set_pressure(16, 16);
         endcase
         target  = bytes_sent + PHASE_BYTES;
         buffers = 0;
         while (bytes_sent < target) begin
            random_buffer();
            buffers++;
            // let the result side run dry now and then
            if (buffers % 10 == 0)
               wait_idle();
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_good_frames();
      test_rejections();
      test_longest_frame();
      test_random_traffic();
      wait_idle();
      if (fail_count == 0)
         $display("xor_checked_frame_receiver_core_tb passed");
      else
         $display("xor_checked_frame_receiver_core_tb failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("xor_checked_frame_receiver_core_tb failed");
      $finish;
   end

endmodule
